// ----- rtl/ckf_pkg.sv -----
// ----------------------------------------------------------------------------
// ckf_pkg: shared types and constants of the 3-D constant-velocity tracker
// Action codes, register indexes, fixed-point limits, the store request bundle
// and the small saturating helpers used by the datapath.
// ----------------------------------------------------------------------------
package ckf_pkg;

  // Action codes carried on the input channel.
  localparam logic [1:0] ACT_RESET   = 2'd0;
  localparam logic [1:0] ACT_PREDICT = 2'd1;
  localparam logic [1:0] ACT_UPDATE  = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POS_NOISE  = 2'd0;
  localparam logic [1:0] CFG_VEL_NOISE  = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE = 2'd2;

  // Time step limits, Q2.16 seconds.
  localparam logic [17:0] DT_MIN = 18'd66;
  localparam logic [17:0] DT_MAX = 18'd131072;

  // Covariance limits, Q32.16.
  localparam logic [47:0] MAX48    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ONE_Q16  = 48'd65536;
  localparam logic [47:0] GAIN_CAP = 48'h4_0000_0000;

  // Store geometry: state words (prior p/v, posterior p/v) and covariances.
  localparam int ST_DEPTH = 12;
  localparam int CV_DEPTH = 18;

  localparam logic signed [36:0] S32_MAX = 37'sd2147483647;
  localparam logic signed [36:0] S32_MIN = -37'sd2147483648;

  // One cycle of requests to the state and covariance memories.
  typedef struct packed {
    logic        s_we;
    logic [3:0]  s_waddr;
    logic [31:0] s_wdata;
    logic [3:0]  s_raddr;
    logic        c_we;
    logic [4:0]  c_waddr;
    logic [47:0] c_wdata;
    logic [4:0]  c_raddr;
    logic        clr_state;
  } mem_req_t;

  // Unsigned 48-bit add that sticks at full scale.
  function automatic logic [47:0] add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  // Saturate a 37-bit signed value into the 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > S32_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ckf_store.sv -----
// ----------------------------------------------------------------------------
// ckf_store: state and covariance memories
// Two single-port-write, one-read memories with registered read data. Valid
// bits make never-written entries read as zero; the state words can be
// cleared at once by the reset action.
// ----------------------------------------------------------------------------
module ckf_store import ckf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mem_req_t    req,
  output logic [31:0] s_rdata,
  output logic [47:0] c_rdata
);

  logic [31:0]         s_mem [ST_DEPTH];
  logic [47:0]         c_mem [CV_DEPTH];
  logic [ST_DEPTH-1:0] s_vld_r;
  logic [CV_DEPTH-1:0] c_vld_r;
  logic [31:0]         s_q_r;
  logic [47:0]         c_q_r;
  logic                s_qv_r;
  logic                c_qv_r;

  // Memory arrays: write, then registered read.
  always_ff @(posedge clk) begin
    if (req.s_we) begin
      s_mem[req.s_waddr] <= req.s_wdata;
    end
    if (req.c_we) begin
      c_mem[req.c_waddr] <= req.c_wdata;
    end
    s_q_r <= s_mem[req.s_raddr];
    c_q_r <= c_mem[req.c_raddr];
  end

  // Valid bits follow the writes and travel with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= '0;
      c_vld_r <= '0;
      s_qv_r  <= 1'b0;
      c_qv_r  <= 1'b0;
    end else begin
      if (req.clr_state) begin
        s_vld_r <= '0;
      end else if (req.s_we) begin
        s_vld_r[req.s_waddr] <= 1'b1;
      end
      if (req.c_we) begin
        c_vld_r[req.c_waddr] <= 1'b1;
      end
      s_qv_r <= s_vld_r[req.s_raddr];
      c_qv_r <= c_vld_r[req.c_raddr];
    end
  end

  assign s_rdata = s_qv_r ? s_q_r : '0;
  assign c_rdata = c_qv_r ? c_q_r : '0;

endmodule

// ----- rtl/ckf_mul.sv -----
// ----------------------------------------------------------------------------
// ckf_mul: shared 48 x 48 unsigned multiplier
// One 48 x 16 partial product per cycle, high chunk first. done pulses for
// one cycle with the full 96-bit product.
// ----------------------------------------------------------------------------
module ckf_mul import ckf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] a,
  input  logic [47:0] b,
  output logic        done,
  output logic [95:0] prod
);

  logic [47:0] a_r;
  logic [47:0] b_r;
  logic [95:0] acc_r;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] pp;
  logic [95:0] acc_nxt;

  // Partial product of the current chunk, folded into the shifted sum.
  assign pp      = {16'b0, a_r} * {48'b0, b_r[47:32]};
  assign acc_nxt = {acc_r[79:0], 16'b0} + {32'b0, pp};

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[31:0], 16'b0};
    end
  end

  // Chunk counter and completion strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd2;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 2'd1;
        if (cnt_r == 2'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- rtl/ckf_div.sv -----
// ----------------------------------------------------------------------------
// ckf_div: capped restoring divider
// Returns floor(num / den) limited to a cap. The high part of the numerator is
// checked against den first, so only 48 (full-scale cap) or 35 (gain cap)
// quotient bits are developed, one per cycle.
// ----------------------------------------------------------------------------
module ckf_div import ckf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [96:0] num,
  input  logic [48:0] den,
  input  logic        gain_cap,
  output logic        done,
  output logic [47:0] quo
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_INIT = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]  ph_r;
  logic [96:0] num_r;
  logic [48:0] den_r;
  logic        sel_r;
  logic [48:0] rem_r;
  logic [47:0] lo_r;
  logic [47:0] q_r;
  logic [5:0]  cnt_r;
  logic        ovf_r;
  logic        done_r;
  logic [47:0] quo_r;
  logic [48:0] hi48;
  logic [61:0] hi35;
  logic        ovf;
  logic [49:0] trial;
  logic        ge;
  logic [49:0] diff;

  // Overflow test: the quotient reaches 2^L exactly when num >> L >= den.
  assign hi48 = num_r[96:48];
  assign hi35 = num_r[96:35];
  assign ovf  = sel_r ? (hi35 >= {13'b0, den_r}) : (hi48 >= den_r);

  // One restoring step.
  assign trial = {rem_r, lo_r[47]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      sel_r <= gain_cap;
    end
    unique case (ph_r)
      PH_INIT: begin
        ovf_r <= ovf;
        q_r   <= '0;
        rem_r <= sel_r ? hi35[48:0] : hi48;
        lo_r  <= sel_r ? {num_r[34:0], 13'b0} : num_r[47:0];
        cnt_r <= sel_r ? 6'd35 : 6'd48;
      end
      PH_RUN: begin
        rem_r <= ge ? diff[48:0] : trial[48:0];
        q_r   <= {q_r[46:0], ge};
        lo_r  <= {lo_r[46:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
      end
      PH_FIN: begin
        if (ovf_r) begin
          quo_r <= sel_r ? GAIN_CAP : MAX48;
        end else if (sel_r && (q_r > GAIN_CAP)) begin
          quo_r <= GAIN_CAP;
        end else begin
          quo_r <= q_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Phase control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: begin
          if (start) begin
            ph_r <= PH_INIT;
          end
        end
        PH_INIT: begin
          ph_r <= ovf ? PH_FIN : PH_RUN;
        end
        PH_RUN: begin
          if (cnt_r == 6'd1) begin
            ph_r <= PH_FIN;
          end
        end
        PH_FIN: begin
          ph_r   <= PH_IDLE;
          done_r <= 1'b1;
        end
        default: begin
          ph_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ----- rtl/constant_velocity_kalman_3d_core.sv -----
// ----------------------------------------------------------------------------
// constant_velocity_kalman_3d_core: 3-D constant-velocity Kalman tracker
// Three independent position/velocity filters kept in a state memory and a
// covariance memory, processed one axis at a time by a sequencer that shares
// one multiplier and one divider.
//
//   channel  | direction | handshake         | beat contents
//   in_      | input     | in_valid/in_stall | action, step_time, meas_x/y/z
//   out_     | output    | out_valid/out_stall | pos_x/y/z
//   cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item is in work at a time. A tracking update is paced by the
// one-bit-per-cycle divider (five capped divisions per axis) and a predict
// by the multiplier; reset, seed and idle actions use neither unit. A new
// beat is taken while the previous result still waits on out_stall. Reset
// is synchronous, active low.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_3d_core import ckf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [17:0]        in_step_time,
  input  logic signed [31:0] in_meas_x,
  input  logic signed [31:0] in_meas_y,
  input  logic signed [31:0] in_meas_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SEED   = 5'd1;
  localparam logic [4:0] S_RD_A   = 5'd2;
  localparam logic [4:0] S_RD_B   = 5'd3;
  localparam logic [4:0] S_RD_C   = 5'd4;
  localparam logic [4:0] S_RD_D   = 5'd5;
  localparam logic [4:0] S_PMUL   = 5'd6;
  localparam logic [4:0] S_PWAIT  = 5'd7;
  localparam logic [4:0] S_PADD   = 5'd8;
  localparam logic [4:0] S_USET   = 5'd9;
  localparam logic [4:0] S_UMUL   = 5'd10;
  localparam logic [4:0] S_UMWAIT = 5'd11;
  localparam logic [4:0] S_UDWAIT = 5'd12;
  localparam logic [4:0] S_UADD   = 5'd13;
  localparam logic [4:0] S_WR     = 5'd14;
  localparam logic [4:0] S_NEXT   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  localparam logic [1:0] MD_PRED = 2'd0;
  localparam logic [1:0] MD_UPD  = 2'd1;
  localparam logic [1:0] MD_READ = 2'd2;

  logic [4:0]  state_r;
  logic [1:0]  md_r;
  logic [1:0]  ax_r;
  logic [2:0]  u_r;
  logic [3:0]  wk_r;
  logic [17:0] dtc_r;
  logic [31:0] mz_r [3];
  logic        trk_r;
  logic [31:0] pn_r;
  logic [31:0] vn_r;
  logic [31:0] mn_r;
  logic [31:0] w_p_r;
  logic [31:0] w_v_r;
  logic [47:0] w_c00_r;
  logic [47:0] w_c01_r;
  logic [47:0] w_c11_r;
  logic [47:0] n00_r;
  logic [47:0] n01_r;
  logic [47:0] n11_r;
  logic [48:0] s_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [34:0] dp_r;
  logic [34:0] dv_r;
  logic signed [34:0] rv_r;
  logic [31:0] pnew_r;
  logic [31:0] vnew_r;
  logic [31:0] res_r [3];
  logic        out_valid_r;
  logic [31:0] out_x_r;
  logic [31:0] out_y_r;
  logic [31:0] out_z_r;

  mem_req_t    mreq;
  logic [31:0] s_rdata;
  logic [47:0] c_rdata;
  logic        mul_start;
  logic [47:0] mul_a;
  logic [47:0] mul_b;
  logic        mul_done;
  logic [95:0] mul_prod;
  logic        div_start;
  logic [96:0] div_num;
  logic        div_done;
  logic [47:0] div_quo;

  logic        in_acc;
  logic [17:0] dt_clamp;
  logic [31:0] r_eff;
  logic [31:0] v_abs;
  logic [4:0]  ax3;
  logic [3:0]  pidx;
  logic [3:0]  vidx;
  logic [4:0]  cidx;
  logic [65:0] tsum;
  logic [47:0] tq48;
  logic signed [50:0] px;
  logic signed [50:0] rx;
  logic signed [36:0] p37;
  logic signed [36:0] v37;
  logic signed [36:0] dp37;
  logic signed [36:0] dv37;
  logic [31:0] pnew_pred;
  logic [31:0] pnew_upd;
  logic [31:0] vnew_upd;
  logic [32:0] ez;
  logic [32:0] ez_abs;
  logic        out_load;

  // Units.
  ckf_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .s_rdata (s_rdata),
    .c_rdata (c_rdata)
  );

  ckf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ckf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (div_num),
    .den      (s_r),
    .gain_cap (u_r < 3'd2),
    .done     (div_done),
    .quo      (div_quo)
  );

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Operand preparation.
  assign dt_clamp = (in_step_time < DT_MIN) ? DT_MIN :
                    (in_step_time > DT_MAX) ? DT_MAX : in_step_time;
  assign r_eff    = (mn_r == 32'd0) ? 32'd1 : mn_r;
  assign v_abs    = w_v_r[31] ? (~w_v_r + 32'd1) : w_v_r;
  assign ax3      = {3'b0, ax_r} + {2'b0, ax_r, 1'b0};
  assign pidx     = ((md_r == MD_UPD) ? 4'd0 : 4'd6) + {2'b0, ax_r};
  assign vidx     = pidx + 4'd3;
  assign cidx     = ((md_r == MD_PRED) ? 5'd9 : 5'd0) + ax3;

  // Product by dt, rounded and saturated to 48 bits.
  assign tsum = {1'b0, mul_prod[64:0]} + 66'd32768;
  assign tq48 = (tsum[65:64] != 2'b00) ? MAX48 : tsum[63:16];

  // Velocity step v*dt rounded to Q16 (floor of value plus one half).
  assign px = $signed({1'b0, mul_prod[49:0]});
  assign rx = w_v_r[31] ? (51'sd32768 - px) : (px + 51'sd32768);

  // Position and velocity sums.
  assign p37       = {{5{w_p_r[31]}}, w_p_r};
  assign v37       = {{5{w_v_r[31]}}, w_v_r};
  assign pnew_pred = sat32(p37 + {{2{rv_r[34]}}, rv_r});
  assign dp37      = neg_r ? -$signed({2'b0, dp_r}) : $signed({2'b0, dp_r});
  assign dv37      = neg_r ? -$signed({2'b0, dv_r}) : $signed({2'b0, dv_r});
  assign pnew_upd  = sat32(p37 + dp37);
  assign vnew_upd  = sat32(v37 + dv37);

  // Innovation.
  assign ez     = {mz_r[ax_r][31], mz_r[ax_r]} - {w_p_r[31], w_p_r};
  assign ez_abs = ez[32] ? (~ez + 33'd1) : ez;

  // Division numerator: product plus half the divisor, for round half up.
  assign div_num   = {1'b0, mul_prod} + {48'b0, s_r[48:1]};
  assign div_start = (state_r == S_UMWAIT) && mul_done;
  assign mul_start = (state_r == S_PMUL) || (state_r == S_UMUL);

  // Multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_PMUL) begin
      unique case (u_r)
        3'd0: begin
          mul_a = {30'b0, dtc_r};
          mul_b = w_c11_r;
        end
        3'd1: begin
          mul_a = {30'b0, dtc_r};
          mul_b = w_c01_r;
        end
        3'd2: begin
          mul_a = {30'b0, dtc_r};
          mul_b = n01_r;
        end
        default: begin
          mul_a = {16'b0, v_abs};
          mul_b = {30'b0, dtc_r};
        end
      endcase
    end else begin
      unique case (u_r)
        3'd0: begin
          mul_a = w_c00_r;
          mul_b = {16'b0, mag_r};
        end
        3'd1: begin
          mul_a = w_c01_r;
          mul_b = {16'b0, mag_r};
        end
        3'd2: begin
          mul_a = w_c00_r;
          mul_b = {16'b0, r_eff};
        end
        3'd3: begin
          mul_a = w_c01_r;
          mul_b = {16'b0, r_eff};
        end
        default: begin
          mul_a = w_c01_r;
          mul_b = w_c01_r;
        end
      endcase
    end
  end

  // Memory requests: fetch reads; seed and write-back writes.
  always_comb begin
    mreq           = '0;
    mreq.clr_state = in_acc && (in_action == ACT_RESET);
    unique case (state_r)
      S_RD_A: begin
        mreq.s_raddr = pidx;
        mreq.c_raddr = cidx;
      end
      S_RD_B: begin
        mreq.s_raddr = vidx;
        mreq.c_raddr = cidx + 5'd1;
      end
      S_RD_C: begin
        mreq.c_raddr = cidx + 5'd2;
      end
      S_SEED: begin
        mreq.s_we    = (wk_r < 4'd6);
        mreq.s_waddr = 4'd6 + wk_r;
        mreq.s_wdata = (wk_r < 4'd3) ? mz_r[wk_r[1:0]] : 32'd0;
        mreq.c_we    = 1'b1;
        mreq.c_waddr = 5'd9 + {1'b0, wk_r};
        mreq.c_wdata = ((wk_r == 4'd1) || (wk_r == 4'd4) || (wk_r == 4'd7)) ?
                       48'd0 : ONE_Q16;
      end
      S_WR: begin
        if (md_r == MD_PRED) begin
          // Prior and posterior get the same predicted values.
          mreq.c_we = 1'b1;
          unique case (wk_r)
            4'd0: begin
              mreq.c_waddr = ax3;
              mreq.c_wdata = n00_r;
              mreq.s_we    = 1'b1;
              mreq.s_waddr = {2'b0, ax_r};
              mreq.s_wdata = pnew_r;
            end
            4'd1: begin
              mreq.c_waddr = ax3 + 5'd1;
              mreq.c_wdata = n01_r;
              mreq.s_we    = 1'b1;
              mreq.s_waddr = 4'd3 + {2'b0, ax_r};
              mreq.s_wdata = w_v_r;
            end
            4'd2: begin
              mreq.c_waddr = ax3 + 5'd2;
              mreq.c_wdata = n11_r;
              mreq.s_we    = 1'b1;
              mreq.s_waddr = 4'd6 + {2'b0, ax_r};
              mreq.s_wdata = pnew_r;
            end
            4'd3: begin
              mreq.c_waddr = ax3 + 5'd9;
              mreq.c_wdata = n00_r;
              mreq.s_we    = 1'b1;
              mreq.s_waddr = 4'd9 + {2'b0, ax_r};
              mreq.s_wdata = w_v_r;
            end
            4'd4: begin
              mreq.c_waddr = ax3 + 5'd10;
              mreq.c_wdata = n01_r;
            end
            default: begin
              mreq.c_waddr = ax3 + 5'd11;
              mreq.c_wdata = n11_r;
            end
          endcase
        end else begin
          // Update writes the posterior only.
          mreq.c_we = 1'b1;
          unique case (wk_r)
            4'd0: begin
              mreq.c_waddr = ax3 + 5'd9;
              mreq.c_wdata = n00_r;
              mreq.s_we    = 1'b1;
              mreq.s_waddr = 4'd6 + {2'b0, ax_r};
              mreq.s_wdata = pnew_r;
            end
            4'd1: begin
              mreq.c_waddr = ax3 + 5'd10;
              mreq.c_wdata = n01_r;
              mreq.s_we    = 1'b1;
              mreq.s_waddr = 4'd9 + {2'b0, ax_r};
              mreq.s_wdata = vnew_r;
            end
            default: begin
              mreq.c_waddr = ax3 + 5'd11;
              mreq.c_wdata = n11_r;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= 32'd655;
      vn_r <= 32'd6554;
      mn_r <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POS_NOISE:  pn_r <= cfg_data;
        CFG_VEL_NOISE:  vn_r <= cfg_data;
        CFG_MEAS_NOISE: mn_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dtc_r    <= dt_clamp;
      mz_r[0]  <= in_meas_x;
      mz_r[1]  <= in_meas_y;
      mz_r[2]  <= in_meas_z;
      if ((in_action == ACT_UPDATE) && !trk_r) begin
        res_r[0] <= in_meas_x;
        res_r[1] <= in_meas_y;
        res_r[2] <= in_meas_z;
      end else begin
        res_r[0] <= '0;
        res_r[1] <= '0;
        res_r[2] <= '0;
      end
    end
    unique case (state_r)
      S_RD_B: begin
        w_p_r   <= s_rdata;
        w_c00_r <= c_rdata;
        if (md_r == MD_READ) begin
          res_r[ax_r] <= s_rdata;
        end
      end
      S_RD_C: begin
        w_v_r   <= s_rdata;
        w_c01_r <= c_rdata;
      end
      S_RD_D: begin
        w_c11_r <= c_rdata;
      end
      S_PMUL: begin
        if (u_r == 3'd3) begin
          n00_r <= add48(n00_r, pn_r);
          n11_r <= add48(w_c11_r, {16'b0, vn_r});
        end
      end
      S_PWAIT: begin
        if (mul_done) begin
          unique case (u_r)
            3'd0:    n01_r <= add48(w_c01_r, tq48);
            3'd1:    n00_r <= add48(w_c00_r, tq48);
            3'd2:    n00_r <= add48(n00_r, tq48);
            default: rv_r  <= rx[50:16];
          endcase
        end
      end
      S_PADD: begin
        pnew_r      <= pnew_pred;
        res_r[ax_r] <= pnew_pred;
      end
      S_USET: begin
        s_r   <= {1'b0, w_c00_r} + {17'b0, r_eff};
        mag_r <= ez_abs[31:0];
        neg_r <= ez[32];
      end
      S_UDWAIT: begin
        if (div_done) begin
          unique case (u_r)
            3'd0:    dp_r  <= div_quo[34:0];
            3'd1:    dv_r  <= div_quo[34:0];
            3'd2:    n00_r <= div_quo;
            3'd3:    n01_r <= div_quo;
            default: n11_r <= (w_c11_r > div_quo) ? (w_c11_r - div_quo) : 48'd0;
          endcase
        end
      end
      S_UADD: begin
        pnew_r      <= pnew_upd;
        vnew_r      <= vnew_upd;
        res_r[ax_r] <= pnew_upd;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      md_r    <= MD_READ;
      ax_r    <= '0;
      u_r     <= '0;
      wk_r    <= '0;
      trk_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          ax_r <= '0;
          u_r  <= '0;
          wk_r <= '0;
          if (in_valid) begin
            unique case (in_action)
              ACT_RESET: begin
                trk_r   <= 1'b0;
                state_r <= S_DONE;
              end
              ACT_PREDICT: begin
                md_r    <= MD_PRED;
                state_r <= trk_r ? S_RD_A : S_DONE;
              end
              ACT_UPDATE: begin
                md_r    <= MD_UPD;
                state_r <= trk_r ? S_RD_A : S_SEED;
              end
              default: begin
                md_r    <= MD_READ;
                state_r <= S_RD_A;
              end
            endcase
          end
        end
        S_SEED: begin
          wk_r <= wk_r + 4'd1;
          if (wk_r == 4'd8) begin
            trk_r   <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_RD_A: state_r <= S_RD_B;
        S_RD_B: state_r <= (md_r == MD_READ) ? S_NEXT : S_RD_C;
        S_RD_C: state_r <= S_RD_D;
        S_RD_D: state_r <= (md_r == MD_PRED) ? S_PMUL : S_USET;
        S_PMUL: state_r <= S_PWAIT;
        S_PWAIT: begin
          if (mul_done) begin
            u_r     <= u_r + 3'd1;
            state_r <= (u_r == 3'd3) ? S_PADD : S_PMUL;
          end
        end
        S_PADD: state_r <= S_WR;
        S_USET: state_r <= S_UMUL;
        S_UMUL: state_r <= S_UMWAIT;
        S_UMWAIT: begin
          if (mul_done) begin
            state_r <= S_UDWAIT;
          end
        end
        S_UDWAIT: begin
          if (div_done) begin
            u_r     <= u_r + 3'd1;
            state_r <= (u_r == 3'd4) ? S_UADD : S_UMUL;
          end
        end
        S_UADD: state_r <= S_WR;
        S_WR: begin
          wk_r <= wk_r + 4'd1;
          if (((md_r == MD_PRED) && (wk_r == 4'd5)) ||
              ((md_r != MD_PRED) && (wk_r == 4'd2))) begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          u_r  <= '0;
          wk_r <= '0;
          ax_r <= ax_r + 2'd1;
          state_r <= (ax_r == 2'd2) ? S_DONE : S_RD_A;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register: holds a result beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r <= res_r[0];
      out_y_r <= res_r[1];
      out_z_r <= res_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_pos_z = out_z_r;

endmodule

// ----- rtl/ckf_checker.sv -----
// ----------------------------------------------------------------------------
// ckf_checker: port-level checks of the tracker
// Watches the handshakes on the top-level ports and is bound to the top.
// ----------------------------------------------------------------------------
module ckf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_action,
  input logic [17:0]        in_step_time,
  input logic signed [31:0] in_meas_x,
  input logic signed [31:0] in_meas_y,
  input logic signed [31:0] in_meas_z,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_pos_y,
  input logic signed [31:0] out_pos_z,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // An accepted beat makes the block busy on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a beat was taken");

  // A fresh result appears only as the block returns to idle.
  a_rose_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result offered while the block is busy");

  // Reset leaves the block idle with no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the channels");

endmodule

bind constant_velocity_kalman_3d_core ckf_checker u_ckf_checker (.*);

// ----- bench/constant_velocity_kalman_3d_checker.sv -----
// ----------------------------------------------------------------------------
// constant_velocity_kalman_3d_checker: tracker scoreboard
// Watches the input, result and register channels of the tracker, keeps its
// own copy of the filter state, predicts each result beat and compares it
// with what the block delivers.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_3d_checker import ckf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [17:0]        in_step_time,
  input  logic signed [31:0] in_meas_x,
  input  logic signed [31:0] in_meas_y,
  input  logic signed [31:0] in_meas_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_pos_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } position_t;

  localparam logic [63:0] Q16_HALF = 64'd32768;

  // Tracker copy.
  logic [31:0] noise_pos, noise_vel, noise_meas;
  logic        tracking;
  logic [31:0] pri_st [6];
  logic [31:0] post_st [6];
  logic [47:0] pri_cv [9];
  logic [47:0] post_cv [9];
  position_t   expected_pos [$];

  // Saturating 32-bit clamp of a wide signed value.
  function automatic logic [31:0] clamp32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -72'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [47:0] sum48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  // Product with a Q16 time step, rounded, saturated to 48 bits.
  function automatic logic [47:0] scale_dt(input logic [63:0] dt, input logic [63:0] c);
    logic [127:0] p;
    p = dt * c + Q16_HALF;
    if (dt * c > 128'hFFFF_FFFF_FFFF_FFFF - Q16_HALF) return MAX48;
    p = p >> 16;
    return (p > MAX48) ? MAX48 : p[47:0];
  endfunction

  // round(a*b/d) half up, capped.
  function automatic logic [63:0] ratio(input logic [63:0] a, input logic [63:0] b,
                                        input logic [63:0] d, input logic [63:0] cap);
    logic [127:0] n, q;
    n = a * b + (d >> 1);
    q = n / d;
    return (q > cap) ? cap : q[63:0];
  endfunction

  // Signed round to nearest of v / 2^16, ties up.
  function automatic logic signed [71:0] round_q16s(input logic signed [71:0] v);
    logic signed [71:0] t;
    t = v + 72'sd32768;
    if (t >= 0) return t / 72'sd65536;
    return -((-t + 72'sd65535) / 72'sd65536);
  endfunction

  task automatic predict_axis(input int i, input logic [63:0] dt);
    logic signed [71:0] p, v;
    logic [47:0] n00, n01;
    p = $signed(post_st[i]);
    v = $signed(post_st[i+3]);
    n01 = sum48(post_cv[3*i+1], scale_dt(dt, post_cv[3*i+2]));
    n00 = sum48(sum48(sum48(post_cv[3*i], scale_dt(dt, post_cv[3*i+1])),
                      scale_dt(dt, n01)), {16'd0, noise_pos});
    pri_st[i] = clamp32(p + round_q16s(v * $signed({8'd0, dt})));
    pri_st[i+3] = post_st[i+3];
    pri_cv[3*i] = n00;
    pri_cv[3*i+1] = n01;
    pri_cv[3*i+2] = sum48(post_cv[3*i+2], {16'd0, noise_vel});
  endtask

  task automatic correct_axis(input int i, input logic signed [31:0] z);
    logic signed [71:0] p, v, e, dp, dv;
    logic [63:0] r, s, mag, t, c00, c01, c11;
    p = $signed(pri_st[i]);
    v = $signed(pri_st[i+3]);
    c00 = pri_cv[3*i];
    c01 = pri_cv[3*i+1];
    c11 = pri_cv[3*i+2];
    r = (noise_meas == 0) ? 64'd1 : {32'd0, noise_meas};
    s = c00 + r;
    e = $signed({{40{z[31]}}, z}) - p;
    mag = (e < 0) ? -e : e;
    dp = $signed({8'd0, ratio(c00, mag, s, {16'd0, GAIN_CAP})});
    dv = $signed({8'd0, ratio(c01, mag, s, {16'd0, GAIN_CAP})});
    if (e < 0) begin
      dp = -dp;
      dv = -dv;
    end
    post_st[i] = clamp32(p + dp);
    post_st[i+3] = clamp32(v + dv);
    post_cv[3*i] = ratio(c00, r, s, {16'd0, MAX48});
    post_cv[3*i+1] = ratio(c01, r, s, {16'd0, MAX48});
    t = ratio(c01, c01, s, {16'd0, MAX48});
    post_cv[3*i+2] = (c11 > t) ? c11 - t : 0;
  endtask

  // Apply one accepted beat and return the position it should produce.
  task automatic track_beat(input logic [1:0] act, input logic [17:0] st,
                            input logic [31:0] z [3], output position_t res);
    logic [63:0] dt;
    res = '0;
    case (act)
      ACT_RESET: begin
        tracking = 1'b0;
        for (int k = 0; k < 6; k++) begin
          pri_st[k] = '0;
          post_st[k] = '0;
        end
      end
      ACT_PREDICT: begin
        if (tracking) begin
          dt = st;
          if (dt < DT_MIN) dt = DT_MIN;
          if (dt > DT_MAX) dt = DT_MAX;
          for (int k = 0; k < 3; k++) predict_axis(k, dt);
          post_st = pri_st;
          post_cv = pri_cv;
          res = {pri_st[0], pri_st[1], pri_st[2]};
        end
      end
      ACT_UPDATE: begin
        if (!tracking) begin
          for (int k = 0; k < 3; k++) begin
            post_st[k] = z[k];
            post_st[k+3] = '0;
            post_cv[3*k] = ONE_Q16;
            post_cv[3*k+1] = '0;
            post_cv[3*k+2] = ONE_Q16;
          end
          tracking = 1'b1;
        end else begin
          for (int k = 0; k < 3; k++) correct_axis(k, z[k]);
        end
        res = {post_st[0], post_st[1], post_st[2]};
      end
      default: begin
        res = {post_st[0], post_st[1], post_st[2]};
      end
    endcase
  endtask

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    logic [31:0] z [3];
    position_t res, want;
    if (!rst_n) begin
      noise_pos <= 32'd655;
      noise_vel <= 32'd6554;
      noise_meas <= 32'd65536;
      tracking = 1'b0;
      for (int k = 0; k < 6; k++) begin
        pri_st[k] = '0;
        post_st[k] = '0;
      end
      for (int k = 0; k < 9; k++) begin
        pri_cv[k] = '0;
        post_cv[k] = '0;
      end
      expected_pos.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POS_NOISE:  noise_pos = cfg_data;
          CFG_VEL_NOISE:  noise_vel = cfg_data;
          CFG_MEAS_NOISE: noise_meas = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        z[0] = in_meas_x;
        z[1] = in_meas_y;
        z[2] = in_meas_z;
        track_beat(in_action, in_step_time, z, res);
        expected_pos.push_back(res);
      end
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_pos.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pos.pop_front();
          if (want !== {out_pos_x, out_pos_y, out_pos_z}) begin
            if (fail_count < 10) begin
              $display("ERROR: position exp %h %h %h got %h %h %h", want.px, want.py,
                       want.pz, out_pos_x, out_pos_y, out_pos_z);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_pos.size();
  end

endmodule

// ----- bench/constant_velocity_kalman_3d_core_tb.sv -----
// ----------------------------------------------------------------------------
// constant_velocity_kalman_3d_core_tb: tracker testbench
// Drives directed and random tracking sequences, register settings and idle
// and stall patterns into the tracker; a checker beside it scores the results.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_3d_core_tb import ckf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_NONE;
  logic [17:0]        in_step_time = '0;
  logic signed [31:0] in_meas_x = '0;
  logic signed [31:0] in_meas_y = '0;
  logic signed [31:0] in_meas_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_POS_NOISE;
  logic [31:0]        cfg_data = '0;
  int                 fail_count, pending, results_seen;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  bit                 hold_off = 1'b0;
  int                 quiet_cycles = 0;
  int                 items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  constant_velocity_kalman_3d_core DUT (.*);

  constant_velocity_kalman_3d_checker u_checker (.*);

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one beat after a random gap and wait until it is taken.
  task automatic send_beat(input logic [1:0] act, input logic [17:0] st,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_step_time <= st;
    in_meas_x <= x;
    in_meas_y <= y;
    in_meas_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drain all outstanding results, then let the core settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos(input int span);
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(2 * span) - span;
      default: return ($urandom_range(200) - 100) << 16;
    endcase
  endfunction

  function automatic logic [17:0] rand_dt();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(70);
      default: return $urandom_range(131072, 1000);
    endcase
  endfunction

  // Reset, seed, then mostly predict/update pairs near a path, some of them random.
  task automatic random_track(input int n);
    logic [31:0] bx, by, bz;
    logic [1:0]  act;
    bx = rand_pos(1 << 24);
    by = rand_pos(1 << 24);
    bz = rand_pos(1 << 24);
    send_beat(ACT_RESET, '0, '0, '0, '0);
    send_beat(ACT_UPDATE, '0, bx, by, bz);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) act = $urandom_range(3);
      else act = (k % 2) ? ACT_UPDATE : ACT_PREDICT;
      if ($urandom_range(7) == 0) begin
        send_beat(act, rand_dt(), $urandom(), $urandom(), $urandom());
      end else begin
        bx = bx + $urandom_range(8192) - 4096;
        by = by + $urandom_range(8192) - 4096;
        bz = bz + $urandom_range(8192) - 4096;
        send_beat(act, rand_dt(), bx + $urandom_range(2048), by, bz - $urandom_range(2048));
      end
    end
  endtask

  task automatic random_phase(input int n);
    while (n > 0) begin
      random_track(20);
      n -= 22;
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each action and special case at the field extremes.
    send_beat(ACT_PREDICT, 18'd65536, '0, '0, '0);
    send_beat(ACT_NONE, '0, '0, '0, '0);
    send_beat(ACT_UPDATE, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    send_beat(ACT_PREDICT, 18'h3FFFF, '0, '0, '0);
    send_beat(ACT_PREDICT, 18'd0, '0, '0, '0);
    send_beat(ACT_PREDICT, 18'd66, '0, '0, '0);
    send_beat(ACT_UPDATE, '0, 32'h8000_0000, 32'h7FFF_FFFF, '0);
    send_beat(ACT_NONE, 18'h3FFFF, 32'hFFFF_FFFF, '0, '0);
    send_beat(ACT_PREDICT, 18'd131072, '0, '0, '0);
    send_beat(ACT_UPDATE, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_RESET, 18'h3FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(ACT_UPDATE, '0, '0, '0, '0);
    send_beat(ACT_UPDATE, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    drain();

    // Extreme noise settings, zero measurement noise among them.
    write_reg(CFG_POS_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_VEL_NOISE, 32'hFFFF_FFFF);
    write_reg(CFG_MEAS_NOISE, 32'd0);
    for (int k = 0; k < 8; k++) send_beat(ACT_PREDICT, 18'd131072, '0, '0, '0);
    send_beat(ACT_UPDATE, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
    send_beat(ACT_UPDATE, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    drain();

    // Random phases: no idling, sender idle, receiver stall, both.
    write_reg(CFG_POS_NOISE, 32'd655);
    write_reg(CFG_VEL_NOISE, 32'd6554);
    write_reg(CFG_MEAS_NOISE, 32'd65536);
    random_phase(300);

    send_idle_pct = 81;
    write_reg(CFG_POS_NOISE, 32'd0);
    write_reg(CFG_VEL_NOISE, 32'd0);
    write_reg(CFG_MEAS_NOISE, 32'hFFFF_FFFF);
    random_phase(300);

    send_idle_pct = 0;
    recv_stall_pct = 81;
    write_reg(CFG_POS_NOISE, $urandom());
    write_reg(CFG_VEL_NOISE, $urandom());
    write_reg(CFG_MEAS_NOISE, 32'd1);
    random_phase(300);

    send_idle_pct = 28;
    recv_stall_pct = 28;
    write_reg(CFG_POS_NOISE, $urandom_range(100000));
    write_reg(CFG_VEL_NOISE, $urandom_range(100000));
    write_reg(CFG_MEAS_NOISE, $urandom_range(1 << 20, 1));
    random_phase(300);

    // Long receiver hold-off while the sender keeps offering beats.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(200);
    join

    $display("Covered %0d input beats and %0d result beats over five settings,",
             items_sent, results_seen);
    $display("including seeding, reset, clamped steps and a long output hold-off.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
